>>> hw/rtl/pfs_pkg.sv
// Shared constants and command types of the parenthesised-fragment stripper.
`default_nettype none

package pfs_pkg;

   // Default size of the hold store, in bytes.
   localparam int unsigned HOLD_DEPTH_DEF = 63;

   // Depth of the command queue between the front and the back.
   localparam int unsigned CMDQ_DEPTH = 4;

   // Text bytes with a meaning of their own.
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_OPEN  = 8'd40;
   localparam logic [7:0] CH_CLOSE = 8'd41;

   // Work handed from the front to the back.
   typedef enum logic {
      CMD_EMIT,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;    // emit one byte, or replay the hold store
      logic [7:0]   ch;      // byte to emit for CMD_EMIT
      logic         ovf;     // flushed bytes carry the overflow mark
      logic         with_nl; // a newline follows the flushed bytes
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/pfs_req_if.sv
// Input channel: one text byte per word.
`default_nettype none

interface pfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfs_rsp_if.sv
// Result channel: one output byte with its last and overflow marks per word.
`default_nettype none

interface pfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       overflow;

   modport source (output valid, output out_char, output last, output overflow, input ready);
   modport sink (input valid, input out_char, input last, input overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/paren_fragment_stripper.sv
// Top level of the parenthesised-fragment stripper: front, command queue, hold store, back.
//
//   channel   direction  handshake               payload
//   req_bus   in         valid / ready           ch [7:0]
//   rsp_bus   out        valid / ready           out_char [7:0], last, overflow
//
// In passing mode a word is taken every cycle while rsp_bus keeps ready high, and its byte
// reaches rsp_bus through the command queue and then the back's output register. A flush
// of the hold store is paced by its registered read port: the back takes the command, then
// reads and emits each held byte in turn, then the trailing newline when one is due. The
// front takes no word from the moment a flush is queued until the back has finished it, nor
// while the command queue is full. Reset is synchronous and clears the mode, the count,
// the queue and the output register; the hold store needs no clearing. Either channel may
// stall at any time without loss.
`default_nettype none

module paren_fragment_stripper #(
   parameter int unsigned HOLD_DEPTH = pfs_pkg::HOLD_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pfs_req_if.sink     req_bus,
   pfs_rsp_if.source   rsp_bus
);

   localparam int unsigned AddrW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int unsigned CntW  = $clog2(HOLD_DEPTH + 1);

   // Front to queue.
   logic             push;
   pfs_pkg::cmd_type push_cmd;
   logic             q_full;

   // Queue to back.
   pfs_pkg::cmd_type head_cmd;
   logic             q_empty;
   logic             pop;

   // Hold store ports.
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic [7:0]       rd_data;

   // Flush handover: the length is held steady by the front until the back reports done.
   logic [CntW-1:0]  flush_len;
   logic             flush_done;

   pfs_front #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .flush_len  (flush_len),
      .flush_done (flush_done)
   );

   pfs_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // The hold store: written by the front as a fragment builds up, read back by the back
   // only once a flush command has been queued, so the two never touch the same byte at once.
   pfs_ram #(
      .WIDTH (8),
      .DEPTH (HOLD_DEPTH)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfs_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_empty    (q_empty),
      .pop        (pop),
      .flush_len  (flush_len),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .flush_done (flush_done),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

>>> hw/rtl/pfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 63
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pfs_cmd_fifo.sv
// Short command queue between the front and the back.
`default_nettype none

module pfs_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pfs_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output      pfs_pkg::cmd_type head_cmd,
   output      logic             empty,
   output      logic             full
);

   localparam int unsigned PtrW = $clog2(pfs_pkg::CMDQ_DEPTH);
   localparam int unsigned CntW = $clog2(pfs_pkg::CMDQ_DEPTH + 1);

   pfs_pkg::cmd_type entry_ff [pfs_pkg::CMDQ_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty    = (count_ff == CntW'(0));
   assign full     = (count_ff == CntW'(pfs_pkg::CMDQ_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(pfs_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(pfs_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pfs_front.sv
// Front end: accepts words, tracks holding mode, fills the hold store, issues commands.
`default_nettype none

module pfs_front #(
   parameter int unsigned HOLD_DEPTH = pfs_pkg::HOLD_DEPTH_DEF
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   pfs_req_if.sink                                             req_bus,
   input  wire logic                                           q_full,
   output      logic                                           push,
   output      pfs_pkg::cmd_type                               push_cmd,
   output      logic                                           wr_en,
   output      logic [((HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1)-1:0] wr_addr,
   output      logic [7:0]                                     wr_data,
   output      logic [$clog2(HOLD_DEPTH + 1)-1:0]              flush_len,
   input  wire logic                                           flush_done
);

   localparam int unsigned AddrW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int unsigned CntW  = $clog2(HOLD_DEPTH + 1);

   logic            holding_ff, holding_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pend_ff, pend_in;
   logic [CntW-1:0] len_ff, len_in;
   logic            accept;
   logic [CntW-1:0] count_inc;

   // A flush in flight owns the hold store, so nothing is taken until it is done.
   assign req_bus.ready = !q_full && !pend_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign count_inc     = count_ff + CntW'(1);
   assign flush_len     = len_ff;

   always_comb begin
      holding_in = holding_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      len_in     = len_ff;
      push       = 1'b0;
      push_cmd   = '{kind: pfs_pkg::CMD_EMIT, ch: req_bus.ch, ovf: 1'b0, with_nl: 1'b0};
      wr_en      = 1'b0;
      wr_addr    = count_ff[AddrW-1:0];
      wr_data    = req_bus.ch;

      if (flush_done) begin
         pend_in = 1'b0;
      end

      if (accept) begin
         if (req_bus.ch == pfs_pkg::CH_NL) begin
            push = 1'b1;
            if (holding_ff) begin
               push_cmd.kind    = pfs_pkg::CMD_FLUSH;
               push_cmd.with_nl = 1'b1;
               len_in           = count_ff;
               pend_in          = 1'b1;
               holding_in       = 1'b0;
               count_in         = '0;
            end
         end else if (holding_ff && req_bus.ch == pfs_pkg::CH_CLOSE) begin
            holding_in = 1'b0;
            count_in   = '0;
         end else if (holding_ff || req_bus.ch == pfs_pkg::CH_OPEN) begin
            // Append to the hold store; the count is zero when a hold opens.
            wr_en      = 1'b1;
            holding_in = 1'b1;
            count_in   = count_inc;
            if (count_inc == CntW'(HOLD_DEPTH)) begin
               push         = 1'b1;
               push_cmd.kind = pfs_pkg::CMD_FLUSH;
               push_cmd.ovf  = 1'b1;
               len_in       = count_inc;
               pend_in      = 1'b1;
               holding_in   = 1'b0;
               count_in     = '0;
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (reset) begin
         holding_ff <= 1'b0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         holding_ff <= holding_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pfs_back.sv
// Back end: carries out commands and drives the registered result channel.
`default_nettype none

module pfs_back #(
   parameter int unsigned HOLD_DEPTH = pfs_pkg::HOLD_DEPTH_DEF
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire pfs_pkg::cmd_type                               head_cmd,
   input  wire logic                                           q_empty,
   output      logic                                           pop,
   input  wire logic [$clog2(HOLD_DEPTH + 1)-1:0]              flush_len,
   output      logic                                           rd_en,
   output      logic [((HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1)-1:0] rd_addr,
   input  wire logic [7:0]                                     rd_data,
   output      logic                                           flush_done,
   pfs_rsp_if.source                                           rsp_bus
);

   localparam int unsigned AddrW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int unsigned CntW  = $clog2(HOLD_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ,
      ST_DATA,
      ST_NL
   } state_type;

   state_type        state_ff;
   logic [AddrW-1:0] addr_ff;
   logic             ovf_ff;
   logic             nl_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;
   logic             out_free;
   logic             at_end;
   logic             load_out;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign at_end   = (CntW'(addr_ff) + CntW'(1)) == flush_len;
   assign rd_addr  = addr_ff;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = rsp_char_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign rsp_bus.overflow = rsp_ovf_ff;

   always_comb begin
      pop        = 1'b0;
      rd_en      = 1'b0;
      flush_done = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (!q_empty) begin
               pop      = (head_cmd.kind == pfs_pkg::CMD_FLUSH) || out_free;
               load_out = (head_cmd.kind == pfs_pkg::CMD_EMIT) && out_free;
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_DATA: begin
            flush_done = out_free && at_end && !nl_ff;
            load_out   = out_free;
         end
         ST_NL: begin
            flush_done = out_free;
            load_out   = out_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (pop) begin
                  if (head_cmd.kind == pfs_pkg::CMD_FLUSH) begin
                     addr_ff  <= '0;
                     ovf_ff   <= head_cmd.ovf;
                     nl_ff    <= head_cmd.with_nl;
                     state_ff <= ST_READ;
                  end else begin
                     rsp_char_ff  <= head_cmd.ch;
                     rsp_last_ff  <= 1'b1;
                     rsp_ovf_ff   <= 1'b0;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_DATA;
            end
            ST_DATA: begin
               if (out_free) begin
                  rsp_char_ff  <= rd_data;
                  rsp_last_ff  <= at_end && !nl_ff;
                  rsp_ovf_ff   <= ovf_ff;
                  if (!at_end) begin
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= ST_READ;
                  end else if (nl_ff) begin
                     state_ff <= ST_NL;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_NL: begin
               if (out_free) begin
                  rsp_char_ff  <= pfs_pkg::CH_NL;
                  rsp_last_ff  <= 1'b1;
                  rsp_ovf_ff   <= 1'b0;
                  state_ff     <= ST_RUN;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> tb/pfs_strip_checker.sv
// Checker for the fragment stripper: predicts the output text and compares each result word.
`timescale 1ns / 100ps

module pfs_strip_checker #(
   parameter int unsigned HOLD_DEPTH = pfs_pkg::HOLD_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   pfs_req_if   req_mon,
   pfs_rsp_if   rsp_mon,
   output int   failures,
   output int   outstanding
);

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       overflow;
   } out_word_t;

   out_word_t  due_words[$];
   out_word_t  staged;
   out_word_t  want;
   bit         staged_valid = 1'b0;
   bit         holding = 1'b0;
   logic [7:0] held_text[HOLD_DEPTH];
   int         held_count = 0;
   int         mismatches = 0;

   // The newest word of an input byte is kept back so that it can take the last mark.
   task automatic stage_byte(input logic [7:0] c, input logic ovf);
      if (staged_valid) due_words.push_back(staged);
      staged = '{out_char: c, last: 1'b0, overflow: ovf};
      staged_valid = 1'b1;
   endtask

   task automatic flush_hold(input logic ovf);
      for (int i = 0; i < held_count; i++) stage_byte(held_text[i], ovf);
      held_count = 0;
      holding = 1'b0;
   endtask

   task automatic strip_byte(input logic [7:0] b);
      staged_valid = 1'b0;
      if (b == pfs_pkg::CH_NL) begin
         if (holding) flush_hold(1'b0);
         stage_byte(b, 1'b0);
      end else if (!holding) begin
         if (b == pfs_pkg::CH_OPEN) begin
            holding = 1'b1;
            held_text[0] = b;
            held_count = 1;
            if (held_count >= HOLD_DEPTH) flush_hold(1'b1);
         end else begin
            stage_byte(b, 1'b0);
         end
      end else if (b == pfs_pkg::CH_CLOSE) begin
         // The fragment and its closing bracket vanish.
         held_count = 0;
         holding = 1'b0;
      end else begin
         if (held_count < HOLD_DEPTH) begin
            held_text[held_count] = b;
            held_count++;
         end
         if (held_count >= HOLD_DEPTH) flush_hold(1'b1);
      end
      if (staged_valid) begin
         staged.last = 1'b1;
         due_words.push_back(staged);
      end
   endtask

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_words.delete();
         holding = 1'b0;
         held_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) strip_byte(req_mon.ch);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_words.size() == 0) begin
               report($sformatf("unexpected word: out_char %0d last %0b overflow %0b",
                                rsp_mon.out_char, rsp_mon.last, rsp_mon.overflow));
            end else begin
               want = due_words.pop_front();
               if (rsp_mon.out_char !== want.out_char || rsp_mon.last !== want.last
                   || rsp_mon.overflow !== want.overflow) begin
                  report($sformatf({"word mismatch: expected out_char %0d last %0b ",
                                    "overflow %0b, got out_char %0d last %0b overflow %0b"},
                                   want.out_char, want.last, want.overflow,
                                   rsp_mon.out_char, rsp_mon.last, rsp_mon.overflow));
               end
            end
         end
      end
      failures    <= mismatches;
      outstanding <= due_words.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top for the fragment stripper: text stimulus, result-side stalls and the verdict.
`timescale 1ns / 100ps

module tb;
   import pfs_pkg::*;

   // Roughly how many text bytes the run sends before it winds down.
   localparam int unsigned TEXT_ITEMS    = 210;
   // Cycles without any accepted word before the run is declared hung.
   localparam int unsigned STALL_LIMIT   = 2000;
   // Cycles left after the last expected word, so that stray words still show up.
   localparam int unsigned SETTLE_CYCLES = 20;

   // Kinds of text piece that the random part strings together.
   typedef enum int {
      PIECE_PLAIN,
      PIECE_DROPPED,
      PIECE_OPEN_AT_EOL,
      PIECE_NEWLINE,
      PIECE_NOISE,
      PIECE_OVERFLOW
   } piece_kind_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       src_valid = 1'b0;
   logic [7:0] src_ch = 8'h00;
   logic       sink_ready = 1'b0;
   int         fail_total;
   int         words_due;
   int         sent = 0;
   int         quiet_cycles = 0;
   int         stall_left = 0;
   bit         sender_eager = 1'b0;
   bit         sink_eager = 1'b0;

   pfs_req_if req_bus ();
   pfs_rsp_if rsp_bus ();

   assign req_bus.valid = src_valid;
   assign req_bus.ch    = src_ch;
   assign rsp_bus.ready = sink_ready;

   paren_fragment_stripper DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // The checker watches both channels and keeps its own picture of the hold store.
   pfs_strip_checker CHECK (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .failures    (fail_total),
      .outstanding (words_due)
   );

   always #10 clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // An ordinary text byte: anything but the newline and the two brackets.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_NL || b == CH_OPEN || b == CH_CLOSE);
      return b;
   endfunction

   // Fragment contents, with the odd nested opening bracket.
   function automatic logic [7:0] inner_byte();
      if ($urandom_range(0, 7) == 0) return CH_OPEN;
      return plain_byte();
   endfunction

   // Noise leans heavily on the bytes with a meaning of their own.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 3))
         0: return CH_NL;
         1: return CH_OPEN;
         2: return CH_CLOSE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic piece_kind_t choose_piece();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return PIECE_PLAIN;
      if (r < 55) return PIECE_DROPPED;
      if (r < 70) return PIECE_OPEN_AT_EOL;
      if (r < 80) return PIECE_NEWLINE;
      if (r < 97) return PIECE_NOISE;
      return PIECE_OVERFLOW;
   endfunction

   // Offers one byte and holds it until the block takes the word. Valid is only lowered
   // when an idle gap is wanted, and then raised again at a later edge, never the same one.
   task automatic send_byte(input logic [7:0] b);
      int idle;
      idle = sender_eager ? 0 : gap_len();
      if (idle > 0) begin
         src_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      src_valid <= 1'b1;
      src_ch    <= b;
      do @(posedge clock);
      while (!req_bus.ready);
      sent++;
   endtask

   // Stops sending until every expected word has come out. The count seen after an edge
   // already includes whatever was accepted at the previous one.
   task automatic drain();
      src_valid <= 1'b0;
      do @(posedge clock);
      while (words_due != 0);
   endtask

   initial begin
      logic [7:0]  opening[$];
      piece_kind_t piece;

      // Directed opening: the byte extremes passing straight through, a stray closing
      // bracket, a newline with nothing held, a dropped fragment, an empty fragment, a nested
      // pair where the second closing bracket passes, and a fragment cut short by the newline.
      opening = '{8'h00, 8'hFF, CH_CLOSE, CH_NL,
                  CH_OPEN, 8'h78, CH_CLOSE,
                  CH_OPEN, CH_CLOSE,
                  CH_OPEN, CH_OPEN, 8'h79, CH_CLOSE, CH_CLOSE, CH_NL,
                  CH_OPEN, 8'hFF, 8'h00, CH_NL,
                  CH_NL};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_byte(opening[i]);
      drain();

      // The random part always opens with a fragment long enough to fill the hold store.
      piece = PIECE_OVERFLOW;
      while (sent < TEXT_ITEMS) begin
         sender_eager = ($urandom_range(0, 5) == 0);
         case (piece)
            PIECE_PLAIN: begin
               repeat ($urandom_range(1, 8))
                  send_byte(($urandom_range(0, 9) == 0) ? CH_CLOSE : plain_byte());
            end
            PIECE_DROPPED: begin
               send_byte(CH_OPEN);
               repeat ($urandom_range(0, 6)) send_byte(inner_byte());
               send_byte(CH_CLOSE);
            end
            PIECE_OPEN_AT_EOL: begin
               send_byte(CH_OPEN);
               repeat ($urandom_range(0, 6)) send_byte(inner_byte());
               send_byte(CH_NL);
            end
            PIECE_NEWLINE: begin
               send_byte(CH_NL);
            end
            PIECE_NOISE: begin
               repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            end
            default: begin
               // Filling the store forces the overflow flush; up to six more bytes then follow, and a
               // closing bracket on the same line passes unchanged unless one of them opened a new hold.
               send_byte(CH_OPEN);
               repeat (HOLD_DEPTH_DEF - 1 + $urandom_range(0, 6)) send_byte(inner_byte());
               if ($urandom_range(0, 1) == 1) send_byte(CH_CLOSE);
               send_byte(CH_NL);
               drain();
            end
         endcase
         if ($urandom_range(0, 14) == 0) drain();
         piece = choose_piece();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_total == 0 && words_due == 0) begin
         $display("paren_fragment_stripper verification clean");
      end else begin
         $display("paren_fragment_stripper verification failed");
      end
      $finish;
   end

   // Result side: ready drops for random stretches, with eager spells in which it stays high.
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         sink_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         sink_ready <= 1'b1;
         stall_left <= sink_eager ? 0 : gap_len();
      end
      if ($urandom_range(0, 149) == 0) sink_eager <= !sink_eager;
   end

   // Watchdog: any accepted word on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (src_valid && req_bus.ready) || (rsp_bus.valid && sink_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("paren_fragment_stripper verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
